// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the addressing mode unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define CAM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/cam_pkg.sv =====
// Types and constants for the CPU addressing mode unit.
// No dependencies; used by cam_result_fifo, cpu_addressing_mode_unit and the testbench.
package cam_pkg;

   // Addressing modes carried in the start item.
   typedef enum logic [3:0] {
      MODE_IMM  = 4'd0,
      MODE_ZP   = 4'd1,
      MODE_ZPX  = 4'd2,
      MODE_ZPY  = 4'd3,
      MODE_ABS  = 4'd4,
      MODE_IND  = 4'd5,
      MODE_ABSX = 4'd6,
      MODE_ABSY = 4'd7,
      MODE_INDX = 4'd8,
      MODE_INDY = 4'd9
   } mode_type;

   // Pointer fetch progress.
   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_LOW  = 2'd1,
      PHASE_HIGH = 2'd2
   } phase_type;

   // Input item opcodes.
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_PTR   = 2'd0;
   localparam logic [1:0] KIND_DUMMY = 2'd1;
   localparam logic [1:0] KIND_FINAL = 2'd2;

   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 24;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic        extra_cycle;
      logic        last;
   } rsp_type;

   // Which of the two result slots are written into the result queue.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

// ===== rtl/core/cam_result_fifo.sv =====
// Small result queue of the addressing mode unit; takes up to two results a cycle.
// Depends on cam_pkg for the result and push types.
module cam_result_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  cam_pkg::push_type push,
   input  cam_pkg::rsp_type  data_first,
   input  cam_pkg::rsp_type  data_second,
   output logic              space_two,
   output logic              out_valid,
   input  logic              out_ready,
   output cam_pkg::rsp_type  out_data
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cam_pkg::rsp_type entry_ff [DEPTH];
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    count_after_pop;
   logic             pop;

   assign out_valid       = (count_ff != '0);
   assign out_data        = entry_ff[rd_ptr_ff];
   assign pop             = out_valid && out_ready;
   assign count_after_pop = count_ff - CW'(pop);
   // Room for a two-result item once this cycle's transfer leaves.
   assign space_two       = (count_after_pop <= CW'(DEPTH - 2));

   always_comb begin
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      wr_ptr_in = wr_ptr_ff + PW'(push.first) + PW'(push.second);
      count_in  = count_after_pop + CW'(push.first) + CW'(push.second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= data_first;
      end
      if (push.second) begin
         entry_ff[wr_ptr_ff + PW'(1)] <= data_second;
      end
   end

endmodule

// ===== rtl/core/cpu_addressing_mode_unit.sv =====
// Top level of the 8-bit CPU effective address unit.
// Depends on cam_pkg, cam_result_fifo and assert_macros.svh.
//
//   Channel  Direction  Accepted when           Carries
//   req_     in         req_tvalid & tready     start item or returned read byte
//   rsp_     out        rsp_tvalid & tready     pointer read, dummy read or final address
//
// An accepted item is held in the input register while the address logic
// writes its one or two results into a four-entry result queue; each result
// passes from the input register through the result queue to rsp_. One item is taken
// per cycle while the queue has room for two results; a page-crossing abs,X or (ind),Y
// item puts two results on the single result port. Synchronous reset empties both stages
// and idles the pointer fetch. A result stall backs up through the queue into req_tready.
`include "assert_macros.svh"

module cpu_addressing_mode_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[3:0], pc[19:4], operand_low[27:20], operand_high[35:28],
   // index_x[43:36], index_y[51:44], read_data[59:52], zero fill [63:60]
   input  logic [63:0] req_tdata,
   // opcode[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // address[15:0], extra_cycle[16], zero fill [23:17]
   output logic [23:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   // Input register stage.
   logic        in_valid_ff, in_valid_in;
   logic        in_op_ff;
   logic [59:0] in_data_ff;
   logic        consume;
   logic        space_two;

   // Pointer fetch state.
   cam_pkg::phase_type phase_ff, phase_in;
   cam_pkg::mode_type  held_mode_ff, held_mode_in;
   logic [15:0]        ptr_high_addr_ff, ptr_high_addr_in;
   logic [7:0]         ptr_low_byte_ff, ptr_low_byte_in;
   logic [7:0]         held_index_y_ff, held_index_y_in;

   // Unpacked fields of the registered item.
   logic [3:0]  f_mode;
   logic [15:0] f_pc;
   logic [7:0]  f_lo, f_hi, f_x, f_y, f_data;
   logic [15:0] f_word;
   logic [7:0]  zp_indexed;

   // Shared indexed adder.
   logic        idx_sel;
   logic        idx_dummy;
   logic        idx_mark;
   logic [15:0] idx_base;
   logic [7:0]  idx_add;
   logic [15:0] idx_sum;
   logic        idx_cross;

   cam_pkg::rsp_type  res_first, res_second;
   cam_pkg::push_type push;
   cam_pkg::rsp_type  out_data;

   assign f_mode     = in_data_ff[3:0];
   assign f_pc       = in_data_ff[19:4];
   assign f_lo       = in_data_ff[27:20];
   assign f_hi       = in_data_ff[35:28];
   assign f_x        = in_data_ff[43:36];
   assign f_y        = in_data_ff[51:44];
   assign f_data     = in_data_ff[59:52];
   assign f_word     = {f_hi, f_lo};
   assign zp_indexed = f_lo + f_x;

   assign consume     = in_valid_ff && space_two;
   assign req_tready  = !in_valid_ff || consume;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_data_ff <= req_tdata[59:0];
      end
   end

   // The indexed adder serves abs,X and abs,Y on a start item and (ind),Y when
   // the pointer high byte arrives. A dummy read goes out at the base page with
   // the summed low byte whenever the sum leaves that page and the mode asks.
   always_comb begin
      idx_sel   = (in_op_ff == cam_pkg::OP_DATA);
      idx_base  = idx_sel ? {f_data, ptr_low_byte_ff} : f_word;
      idx_add   = idx_sel ? held_index_y_ff
                          : ((f_mode == cam_pkg::MODE_ABSX) ? f_x : f_y);
      idx_dummy = idx_sel || (f_mode == cam_pkg::MODE_ABSX);
      idx_mark  = idx_sel || (f_mode == cam_pkg::MODE_ABSY);
      idx_sum   = idx_base + {8'h00, idx_add};
      idx_cross = (idx_base[15:8] != idx_sum[15:8]);
   end

   always_comb begin
      phase_in         = phase_ff;
      held_mode_in     = held_mode_ff;
      ptr_high_addr_in = ptr_high_addr_ff;
      ptr_low_byte_in  = ptr_low_byte_ff;
      held_index_y_in  = held_index_y_ff;
      push             = '{first: 1'b0, second: 1'b0};
      res_first        = '{kind: cam_pkg::KIND_FINAL, address: 16'h0000,
                           extra_cycle: 1'b0, last: 1'b1};
      res_second       = '{kind: cam_pkg::KIND_FINAL, address: idx_sum,
                           extra_cycle: idx_mark, last: 1'b1};

      if (in_op_ff == cam_pkg::OP_DATA) begin
         case (phase_ff)
            cam_pkg::PHASE_LOW: begin
               // Low pointer byte is in; ask for the high byte.
               ptr_low_byte_in     = f_data;
               phase_in            = cam_pkg::PHASE_HIGH;
               push.first          = 1'b1;
               res_first.kind      = cam_pkg::KIND_PTR;
               res_first.address   = ptr_high_addr_ff;
            end
            cam_pkg::PHASE_HIGH: begin
               phase_in   = cam_pkg::PHASE_IDLE;
               push.first = 1'b1;
               if (held_mode_ff == cam_pkg::MODE_INDY) begin
                  if (idx_cross) begin
                     push.second           = 1'b1;
                     res_first.kind        = cam_pkg::KIND_DUMMY;
                     res_first.address     = {idx_base[15:8], idx_sum[7:0]};
                     res_first.last        = 1'b0;
                  end else begin
                     res_first.address     = idx_sum;
                  end
               end else begin
                  res_first.address = {f_data, ptr_low_byte_ff};
               end
            end
            default: begin
               // Read byte with no fetch pending is dropped.
            end
         endcase
      end else begin
         // A start abandons any pending pointer fetch.
         phase_in = cam_pkg::PHASE_IDLE;
         case (cam_pkg::mode_type'(f_mode))
            cam_pkg::MODE_IMM: begin
               push.first        = 1'b1;
               res_first.address = f_pc + 16'd1;
            end
            cam_pkg::MODE_ZP: begin
               push.first        = 1'b1;
               res_first.address = {8'h00, f_lo};
            end
            cam_pkg::MODE_ZPX: begin
               push.first        = 1'b1;
               res_first.address = {8'h00, zp_indexed};
            end
            cam_pkg::MODE_ZPY: begin
               push.first        = 1'b1;
               res_first.address = {8'h00, f_lo + f_y};
            end
            cam_pkg::MODE_ABS: begin
               push.first        = 1'b1;
               res_first.address = f_word;
            end
            cam_pkg::MODE_ABSX, cam_pkg::MODE_ABSY: begin
               push.first = 1'b1;
               if (idx_cross && idx_dummy) begin
                  push.second       = 1'b1;
                  res_first.kind    = cam_pkg::KIND_DUMMY;
                  res_first.address = {idx_base[15:8], idx_sum[7:0]};
                  res_first.last    = 1'b0;
               end else begin
                  res_first.address     = idx_sum;
                  res_first.extra_cycle = idx_cross && idx_mark;
               end
            end
            cam_pkg::MODE_IND, cam_pkg::MODE_INDX, cam_pkg::MODE_INDY: begin
               // Pointer fetch; the high byte address wraps within its page.
               phase_in          = cam_pkg::PHASE_LOW;
               held_mode_in      = cam_pkg::mode_type'(f_mode);
               held_index_y_in   = f_y;
               push.first        = 1'b1;
               res_first.kind    = cam_pkg::KIND_PTR;
               case (cam_pkg::mode_type'(f_mode))
                  cam_pkg::MODE_IND: begin
                     res_first.address = f_word;
                     ptr_high_addr_in  = {f_hi, f_lo + 8'd1};
                  end
                  cam_pkg::MODE_INDX: begin
                     res_first.address = {8'h00, zp_indexed};
                     ptr_high_addr_in  = {8'h00, zp_indexed + 8'd1};
                  end
                  default: begin
                     res_first.address = {8'h00, f_lo};
                     ptr_high_addr_in  = {8'h00, f_lo + 8'd1};
                  end
               endcase
            end
            default: begin
               // Undefined mode gives no result.
            end
         endcase
      end

      if (!consume) begin
         phase_in         = phase_ff;
         held_mode_in     = held_mode_ff;
         ptr_high_addr_in = ptr_high_addr_ff;
         ptr_low_byte_in  = ptr_low_byte_ff;
         held_index_y_in  = held_index_y_ff;
         push             = '{first: 1'b0, second: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= cam_pkg::PHASE_IDLE;
         held_mode_ff     <= cam_pkg::MODE_IMM;
         ptr_high_addr_ff <= '0;
         ptr_low_byte_ff  <= '0;
         held_index_y_ff  <= '0;
      end else begin
         phase_ff         <= phase_in;
         held_mode_ff     <= held_mode_in;
         ptr_high_addr_ff <= ptr_high_addr_in;
         ptr_low_byte_ff  <= ptr_low_byte_in;
         held_index_y_ff  <= held_index_y_in;
      end
   end

   cam_result_fifo #(
      .DEPTH(4)
   ) u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .data_first (res_first),
      .data_second(res_second),
      .space_two  (space_two),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   assign rsp_tdata = {7'b0000000, out_data.extra_cycle, out_data.address};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

   // A two-result item is always a dummy read followed by the final address.
   `CAM_ASSERT_SAME(a_pair_order, clock, reset, push.second,
      push.first && (res_first.kind == cam_pkg::KIND_DUMMY) && !res_first.last)

   // Only pointer-fetching modes may wait for a pointer high byte.
   `CAM_ASSERT_SAME(a_high_mode, clock, reset, phase_ff == cam_pkg::PHASE_HIGH,
      (held_mode_ff == cam_pkg::MODE_IND) || (held_mode_ff == cam_pkg::MODE_INDX) ||
      (held_mode_ff == cam_pkg::MODE_INDY))

   // Nothing is written into the queue without an item being consumed.
   `CAM_ASSERT_SAME(a_push_consume, clock, reset, push.first, consume)

   // An input transfer always lands in the input register.
   `CAM_ASSERT_NEXT(a_in_capture, clock, reset, req_tvalid && req_tready, in_valid_ff)

endmodule

// ===== sim/tb_cpu_addressing_mode_unit.sv =====
// Self-checking testbench for cpu_addressing_mode_unit, the CPU effective address unit.
// Depends on cam_pkg for mode, phase and result types; drives both stream channels.
// A directed table comes first, then random instruction sequences checked by a predictor.
module tb_cpu_addressing_mode_unit;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // mode[3:0], pc[19:4], operand_low[27:20], operand_high[35:28],
   // index_x[43:36], index_y[51:44], read_data[59:52], zero fill [63:60]
   logic [63:0] req_tdata;
   // opcode[0]
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // address[15:0], extra_cycle[16], zero fill [23:17]
   logic [23:0] rsp_tdata;
   // kind[1:0]
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // One row of stimulus. When typed_count is negative the predictor supplies the
   // expected results, otherwise typed_count results (zero or one) are given in typed.
   typedef struct {
      logic             op;
      logic [3:0]       mode;
      logic [15:0]      pc;
      logic [7:0]       lo;
      logic [7:0]       hi;
      logic [7:0]       x;
      logic [7:0]       y;
      logic [7:0]       data;
      int               typed_count;
      cam_pkg::rsp_type typed;
   } plan_row_type;

   // Predictor state: the pointer fetch in progress.
   cam_pkg::phase_type ptr_phase;
   cam_pkg::mode_type  fetch_mode;
   logic [15:0]        ptr_high_addr;
   logic [7:0]         ptr_low_byte;
   logic [7:0]         fetch_y;

   cam_pkg::rsp_type   step_results[$];
   cam_pkg::rsp_type   pending_bus[$];
   plan_row_type       directed[$];
   int                 bad_count;
   bit                 req_calm;
   bit                 rsp_calm;

   cpu_addressing_mode_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void put_result(input logic [1:0] kind, input logic [15:0] addr,
                                      input logic extra, input logic last);
      cam_pkg::rsp_type r;
      r.kind        = kind;
      r.address     = addr;
      r.extra_cycle = extra;
      r.last        = last;
      step_results.push_back(r);
   endfunction

   // Base plus index with 16-bit wrap. A page crossing can add a dummy read at the
   // uncorrected address and can mark the extra cycle on the final address.
   function automatic void index_add(input logic [15:0] base, input logic [7:0] idx,
                                     input bit dummy_on_cross, input bit mark_cross);
      logic [15:0] sum;
      bit          crossed;
      sum     = base + {8'h00, idx};
      crossed = (base[15:8] != sum[15:8]);
      if (crossed && dummy_on_cross) begin
         put_result(cam_pkg::KIND_DUMMY, {base[15:8], sum[7:0]}, 1'b0, 1'b0);
         put_result(cam_pkg::KIND_FINAL, sum, mark_cross, 1'b1);
      end else begin
         put_result(cam_pkg::KIND_FINAL, sum, crossed && mark_cross, 1'b1);
      end
   endfunction

   function automatic void begin_fetch(input logic [3:0] mode, input logic [15:0] low_addr,
                                       input logic [15:0] high_addr, input logic [7:0] y);
      ptr_phase     = cam_pkg::PHASE_LOW;
      fetch_mode    = cam_pkg::mode_type'(mode);
      ptr_high_addr = high_addr;
      fetch_y       = y;
      put_result(cam_pkg::KIND_PTR, low_addr, 1'b0, 1'b1);
   endfunction

   // Works out the results of one accepted item into step_results.
   function automatic void predict_step(input plan_row_type r);
      logic [7:0]  zp;
      logic [7:0]  lo_next;
      logic [15:0] base;
      zp      = r.lo + r.x;
      lo_next = r.lo + 8'd1;
      if (r.op == cam_pkg::OP_DATA) begin
         if (ptr_phase == cam_pkg::PHASE_LOW) begin
            ptr_low_byte = r.data;
            ptr_phase    = cam_pkg::PHASE_HIGH;
            put_result(cam_pkg::KIND_PTR, ptr_high_addr, 1'b0, 1'b1);
         end else if (ptr_phase == cam_pkg::PHASE_HIGH) begin
            base      = {r.data, ptr_low_byte};
            ptr_phase = cam_pkg::PHASE_IDLE;
            if (fetch_mode == cam_pkg::MODE_INDY) begin
               index_add(base, fetch_y, 1'b1, 1'b1);
            end else begin
               put_result(cam_pkg::KIND_FINAL, base, 1'b0, 1'b1);
            end
         end
         // Read data while idle is ignored.
      end else begin
         // A start always abandons a pointer fetch still in progress.
         ptr_phase = cam_pkg::PHASE_IDLE;
         case (r.mode)
            cam_pkg::MODE_IMM:
               put_result(cam_pkg::KIND_FINAL, r.pc + 16'd1, 1'b0, 1'b1);
            cam_pkg::MODE_ZP:
               put_result(cam_pkg::KIND_FINAL, {8'h00, r.lo}, 1'b0, 1'b1);
            cam_pkg::MODE_ZPX:
               put_result(cam_pkg::KIND_FINAL, {8'h00, zp}, 1'b0, 1'b1);
            cam_pkg::MODE_ZPY:
               put_result(cam_pkg::KIND_FINAL, {8'h00, r.lo + r.y}, 1'b0, 1'b1);
            cam_pkg::MODE_ABS:
               put_result(cam_pkg::KIND_FINAL, {r.hi, r.lo}, 1'b0, 1'b1);
            // The pointer high byte stays in the pointer's page.
            cam_pkg::MODE_IND:
               begin_fetch(r.mode, {r.hi, r.lo}, {r.hi, lo_next}, r.y);
            cam_pkg::MODE_ABSX:
               index_add({r.hi, r.lo}, r.x, 1'b1, 1'b0);
            cam_pkg::MODE_ABSY:
               index_add({r.hi, r.lo}, r.y, 1'b0, 1'b1);
            cam_pkg::MODE_INDX:
               begin_fetch(r.mode, {8'h00, zp}, {8'h00, zp + 8'd1}, r.y);
            cam_pkg::MODE_INDY:
               begin_fetch(r.mode, {8'h00, r.lo}, {8'h00, lo_next}, r.y);
            default: ;
         endcase
      end
   endfunction

   function automatic plan_row_type mk_row(input logic op, input logic [3:0] mode,
                                           input logic [15:0] pc, input logic [7:0] lo,
                                           input logic [7:0] hi, input logic [7:0] x,
                                           input logic [7:0] y, input logic [7:0] data,
                                           input int count, input logic [1:0] kind,
                                           input logic [15:0] addr, input logic extra);
      plan_row_type r;
      r.op                = op;
      r.mode              = mode;
      r.pc                = pc;
      r.lo                = lo;
      r.hi                = hi;
      r.x                 = x;
      r.y                 = y;
      r.data              = data;
      r.typed_count       = count;
      r.typed.kind        = kind;
      r.typed.address     = addr;
      r.typed.extra_cycle = extra;
      r.typed.last        = 1'b1;
      return r;
   endfunction

   function automatic plan_row_type rand_row(input logic op, input logic [3:0] mode);
      return mk_row(op, mode, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), -1, cam_pkg::KIND_FINAL, 16'h0000, 1'b0);
   endfunction

   // Presents one item after a random gap and waits for its transfer.
   task automatic send_item(input plan_row_type r);
      int gap;
      if ($urandom_range(0, 99) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= r.op;
      req_tdata  <= {4'h0, r.data, r.y, r.x, r.hi, r.lo, r.pc, r.mode};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      step_results.delete();
      predict_step(r);
      if (r.typed_count < 0) begin
         foreach (step_results[i]) pending_bus.push_back(step_results[i]);
      end else if (r.typed_count == 1) begin
         pending_bus.push_back(r.typed);
      end
   endtask

   task automatic note_failure(input string what, input cam_pkg::rsp_type want);
      bad_count++;
      if (bad_count <= 10) begin
         $write("%s: expected kind %0d addr %h extra %b last %b, ",
                what, want.kind, want.address, want.extra_cycle, want.last);
         $display("got kind %0d addr %h extra %b last %b",
                  rsp_tuser, rsp_tdata[15:0], rsp_tdata[16], rsp_tlast);
      end
   endtask

   // Result checker: every transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      cam_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bus.size() == 0) begin
            want = '0;
            note_failure("unexpected result", want);
         end else begin
            want = pending_bus.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[15:0] !== want.address ||
                rsp_tdata[16] !== want.extra_cycle || rsp_tlast !== want.last) begin
               note_failure("result mismatch", want);
            end
         end
      end
   end

   // Result receiver: stalls a random number of cycles before each transfer.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 99) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 8);
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int         items;
      int         pick;
      int         reads;
      logic [3:0] m;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      reset      = 1'b1;
      bad_count  = 0;
      req_calm   = 1'b0;
      rsp_calm   = 1'b0;
      ptr_phase  = cam_pkg::PHASE_IDLE;
      fetch_mode = cam_pkg::MODE_IMM;
      ptr_high_addr = '0;
      ptr_low_byte  = '0;
      fetch_y       = '0;

      // Stray read data right after reset.
      directed.push_back(mk_row(cam_pkg::OP_DATA, cam_pkg::MODE_IMM, 16'h0000, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'hA5,
                                0, cam_pkg::KIND_FINAL, 16'h0000, 1'b0));
      // Single-result modes at their extremes, with page and 16-bit wrap.
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_IMM, 16'hFFFF, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'h0000, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_IMM, 16'h0000, 8'hFF,
                                8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                1, cam_pkg::KIND_FINAL, 16'h0001, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ZP, 16'h1234, 8'hFF,
                                8'h00, 8'h00, 8'h00, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'h00FF, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ZPX, 16'h1234, 8'hFF,
                                8'hFF, 8'hFF, 8'h00, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'h00FE, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ZPY, 16'h1234, 8'h80,
                                8'h00, 8'h00, 8'h80, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'h0000, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ABS, 16'h1234, 8'hFF,
                                8'hFF, 8'h00, 8'h00, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'hFFFF, 1'b0));
      // abs,X with a page crossing, the full 16-bit wrap, and no crossing.
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ABSX, 16'h1234, 8'hFF,
                                8'h12, 8'h01, 8'h00, 8'h00,
                                -1, cam_pkg::KIND_FINAL, 16'h0000, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ABSX, 16'h1234, 8'hFF,
                                8'hFF, 8'hFF, 8'h00, 8'h00,
                                -1, cam_pkg::KIND_FINAL, 16'h0000, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ABSX, 16'h1234, 8'h00,
                                8'h12, 8'h10, 8'h00, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'h1210, 1'b0));
      // abs,Y marks the extra cycle on a crossing.
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ABSY, 16'h1234, 8'hFF,
                                8'h12, 8'h00, 8'h01, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'h1300, 1'b1));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ABSY, 16'h1234, 8'h00,
                                8'h12, 8'h00, 8'hFF, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'h12FF, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_ABSY, 16'h1234, 8'hFF,
                                8'hFF, 8'h00, 8'h01, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'h0000, 1'b1));
      // Absolute indirect with the in-page pointer wrap.
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_IND, 16'h1234, 8'hFF,
                                8'h10, 8'h00, 8'h00, 8'h00,
                                1, cam_pkg::KIND_PTR, 16'h10FF, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_DATA, cam_pkg::MODE_IMM, 16'h0000, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'h34,
                                1, cam_pkg::KIND_PTR, 16'h1000, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_DATA, cam_pkg::MODE_IMM, 16'h0000, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'h12,
                                1, cam_pkg::KIND_FINAL, 16'h1234, 1'b0));
      // Indexed indirect wrapping within page zero.
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_INDX, 16'h1234, 8'hFF,
                                8'h00, 8'h01, 8'h00, 8'h00,
                                1, cam_pkg::KIND_PTR, 16'h0000, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_DATA, cam_pkg::MODE_IMM, 16'h0000, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'hFF,
                                1, cam_pkg::KIND_PTR, 16'h0001, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_DATA, cam_pkg::MODE_IMM, 16'h0000, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'hFF,
                                1, cam_pkg::KIND_FINAL, 16'hFFFF, 1'b0));
      // Indirect indexed with the pointer at the top of page zero and a crossing.
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_INDY, 16'h1234, 8'hFF,
                                8'h00, 8'h00, 8'h20, 8'h00,
                                1, cam_pkg::KIND_PTR, 16'h00FF, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_DATA, cam_pkg::MODE_IMM, 16'h0000, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'hF0,
                                1, cam_pkg::KIND_PTR, 16'h0000, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_DATA, cam_pkg::MODE_IMM, 16'h0000, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'h12,
                                -1, cam_pkg::KIND_FINAL, 16'h0000, 1'b0));
      // A new start while a pointer fetch waits, then read data that is now stray.
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_INDY, 16'h1234, 8'h10,
                                8'h00, 8'h00, 8'h00, 8'h00,
                                1, cam_pkg::KIND_PTR, 16'h0010, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, cam_pkg::MODE_IMM, 16'h1234, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'h00,
                                1, cam_pkg::KIND_FINAL, 16'h1235, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_DATA, cam_pkg::MODE_IMM, 16'h0000, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'h55,
                                0, cam_pkg::KIND_FINAL, 16'h0000, 1'b0));
      // Undefined modes give nothing.
      directed.push_back(mk_row(cam_pkg::OP_START, 4'd10, 16'h1234, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'h00,
                                0, cam_pkg::KIND_FINAL, 16'h0000, 1'b0));
      directed.push_back(mk_row(cam_pkg::OP_START, 4'd15, 16'hFFFF, 8'hFF,
                                8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                0, cam_pkg::KIND_FINAL, 16'h0000, 1'b0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_item(directed[i]);

      // Mostly well-formed instructions, pointer fetches answered in full; the rest
      // are broken fetches, undefined modes and stray read data.
      items = 0;
      while (items < 1800) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            m = 4'($urandom_range(0, 9));
            send_item(rand_row(cam_pkg::OP_START, m));
            items++;
            if (m == cam_pkg::MODE_IND || m == cam_pkg::MODE_INDX ||
                m == cam_pkg::MODE_INDY) begin
               reads = ($urandom_range(0, 99) < 85) ? 2 : $urandom_range(0, 1);
               repeat (reads) begin
                  send_item(rand_row(cam_pkg::OP_DATA, 4'($urandom_range(0, 15))));
                  items++;
               end
            end
         end else if (pick < 90) begin
            send_item(rand_row(cam_pkg::OP_START, 4'($urandom_range(10, 15))));
            items++;
         end else begin
            send_item(rand_row(cam_pkg::OP_DATA, 4'($urandom_range(0, 15))));
            items++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_bus.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      if (bad_count == 0 && pending_bus.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
